>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

>>> hw/rtl/dsfe_pkg.sv
// Types, constants and frame builder for the DShot frame pulse encoder.
package dsfe_pkg;

    localparam int CH_MAX       = 6;
    localparam int CHANNELS_DEF = 6;
    localparam int FRAME_BITS   = 16;
    localparam int CMD_W        = 11;
    localparam int TICK_W       = 16;
    localparam int BIDX_W       = $clog2(FRAME_BITS);
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int NIBBLE_W     = 4;

    localparam logic [TICK_W-1:0] SHORT_TICKS_RST = TICK_W'(37);
    localparam logic [TICK_W-1:0] LONG_TICKS_RST  = TICK_W'(75);
    localparam logic [CMD_W-1:0]  MAX_CMD_RST     = CMD_W'(2047);

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_TICKS = 2'd0,
        CFG_LONG_TICKS  = 2'd1,
        CFG_MAX_CMD     = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } state_t;

    typedef logic [FRAME_BITS-1:0] frame_t;

    typedef struct packed {
        logic load;
        logic advance;
    } lane_ctrl_t;

    // Command in the top eleven bits, telemetry bit below, then the nibble XOR.
    function automatic frame_t make_frame(logic [CMD_W-1:0] cmd, logic tlm);
        frame_t f;
        f = {cmd, tlm, {NIBBLE_W{1'b0}}};
        f[NIBBLE_W-1:0] = f[2*NIBBLE_W-1:NIBBLE_W] ^ f[3*NIBBLE_W-1:2*NIBBLE_W]
                        ^ f[4*NIBBLE_W-1:3*NIBBLE_W];
        return f;
    endfunction

endpackage

>>> hw/rtl/dsfe_lane.sv
// One channel lane: range check, frame build and per-bit pulse selection.
module dsfe_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dsfe_pkg::lane_ctrl_t          ctrl,
    input  logic [dsfe_pkg::CMD_W-1:0]    cmd,
    input  logic                          tlm,
    input  logic [dsfe_pkg::CMD_W-1:0]    max_command,
    input  logic [dsfe_pkg::TICK_W-1:0]   short_ticks,
    input  logic [dsfe_pkg::TICK_W-1:0]   long_ticks,
    output logic                          range_err,
    output logic [dsfe_pkg::TICK_W-1:0]   pulse
);
    import dsfe_pkg::*;

    frame_t frame_new;
    frame_t frame_reg;
    frame_t frame_next;
    logic   emit_bit;

    assign frame_new = make_frame(cmd, tlm);
    assign range_err = (cmd > max_command);

    // On load the MSB goes out at once; keep the rest for the following cycles.
    assign emit_bit = ctrl.load ? frame_new[FRAME_BITS-1] : frame_reg[FRAME_BITS-1];
    assign pulse    = emit_bit ? long_ticks : short_ticks;

    always_comb
    begin
        frame_next = frame_reg;
        if (ctrl.load)
        begin
            frame_next = {frame_new[FRAME_BITS-2:0], 1'b0};
        end
        else if (ctrl.advance)
        begin
            frame_next = {frame_reg[FRAME_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
        end
        else
        begin
            frame_reg <= frame_next;
        end
    end

endmodule

>>> hw/rtl/dshot_frame_pulse_encoder_top.sv
// Top level of the DShot frame pulse encoder: lanes, sequencer and result merge.
//
// A transaction is taken when start is high and busy is low. In the cycle
// after, the first result appears with valid high; a good transaction then
// gives sixteen results on consecutive cycles, MSB first, the last one
// marked by last, as the bit counter walks the frame one bit per clock. busy
// is high from the first result to the one before the last, and the next
// transaction can be started while the last result is shown. A command above
// max_command on any active channel gives a single result with status set,
// last set, bit_index zero and all pulse fields zero, and the block is free
// again at once. Results are shown for exactly one cycle and cannot be stalled.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while the block is idle, and the block does not enforce this.
`include "assert_macros.svh"

module dshot_frame_pulse_encoder_top #(
    parameter int CHANNELS = dsfe_pkg::CHANNELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [dsfe_pkg::CMD_W-1:0]        cmd_ch0,
    input  logic [dsfe_pkg::CMD_W-1:0]        cmd_ch1,
    input  logic [dsfe_pkg::CMD_W-1:0]        cmd_ch2,
    input  logic [dsfe_pkg::CMD_W-1:0]        cmd_ch3,
    input  logic [dsfe_pkg::CMD_W-1:0]        cmd_ch4,
    input  logic [dsfe_pkg::CMD_W-1:0]        cmd_ch5,
    input  logic                              tlm_ch0,
    input  logic                              tlm_ch1,
    input  logic                              tlm_ch2,
    input  logic                              tlm_ch3,
    input  logic                              tlm_ch4,
    input  logic                              tlm_ch5,
    output logic                              valid,
    output logic [dsfe_pkg::TICK_W-1:0]       pulse_ch0,
    output logic [dsfe_pkg::TICK_W-1:0]       pulse_ch1,
    output logic [dsfe_pkg::TICK_W-1:0]       pulse_ch2,
    output logic [dsfe_pkg::TICK_W-1:0]       pulse_ch3,
    output logic [dsfe_pkg::TICK_W-1:0]       pulse_ch4,
    output logic [dsfe_pkg::TICK_W-1:0]       pulse_ch5,
    output logic [dsfe_pkg::BIDX_W-1:0]       bit_index,
    output logic                              last,
    output logic                              status,
    input  logic                              cfg_we,
    input  logic [dsfe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dsfe_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import dsfe_pkg::*;

    localparam logic [BIDX_W-1:0] LAST_BIT = BIDX_W'(FRAME_BITS - 1);

    logic [CMD_W-1:0]  cmd_arr  [CH_MAX];
    logic              tlm_arr  [CH_MAX];
    logic [TICK_W-1:0] lane_pulse [CH_MAX];
    logic [CH_MAX-1:0] lane_err;
    logic              range_err;
    lane_ctrl_t        ctrl;

    logic [TICK_W-1:0] short_ticks_reg;
    logic [TICK_W-1:0] long_ticks_reg;
    logic [CMD_W-1:0]  max_cmd_reg;

    state_t            state_reg;
    state_t            state_next;
    logic [BIDX_W-1:0] bit_cnt_reg;
    logic [BIDX_W-1:0] bit_cnt_next;
    logic              valid_reg;
    logic              valid_next;
    logic [BIDX_W-1:0] bit_index_reg;
    logic [BIDX_W-1:0] bit_index_next;
    logic              last_reg;
    logic              last_next;
    logic              status_reg;
    logic              status_next;
    logic              zero_next;
    logic [TICK_W-1:0] pulse_reg  [CH_MAX];
    logic [TICK_W-1:0] pulse_next [CH_MAX];

    assign cmd_arr[0] = cmd_ch0;
    assign cmd_arr[1] = cmd_ch1;
    assign cmd_arr[2] = cmd_ch2;
    assign cmd_arr[3] = cmd_ch3;
    assign cmd_arr[4] = cmd_ch4;
    assign cmd_arr[5] = cmd_ch5;
    assign tlm_arr[0] = tlm_ch0;
    assign tlm_arr[1] = tlm_ch1;
    assign tlm_arr[2] = tlm_ch2;
    assign tlm_arr[3] = tlm_ch3;
    assign tlm_arr[4] = tlm_ch4;
    assign tlm_arr[5] = tlm_ch5;

    for (genvar i = 0; i < CH_MAX; i++)
    begin : g_lane
        if (i < CHANNELS)
        begin : g_on
            dsfe_lane u_lane (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .cmd         (cmd_arr[i]),
                .tlm         (tlm_arr[i]),
                .max_command (max_cmd_reg),
                .short_ticks (short_ticks_reg),
                .long_ticks  (long_ticks_reg),
                .range_err   (lane_err[i]),
                .pulse       (lane_pulse[i])
            );
        end
        else
        begin : g_off
            // Channel not fitted: no range check, pulse held at zero.
            assign lane_err[i]   = 1'b0;
            assign lane_pulse[i] = '0;
        end
    end

    assign range_err = |lane_err;
    assign busy      = (state_reg == ST_SEND);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_ticks_reg <= SHORT_TICKS_RST;
            long_ticks_reg  <= LONG_TICKS_RST;
            max_cmd_reg     <= MAX_CMD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SHORT_TICKS: short_ticks_reg <= cfg_data[TICK_W-1:0];
                CFG_LONG_TICKS:  long_ticks_reg  <= cfg_data[TICK_W-1:0];
                CFG_MAX_CMD:     max_cmd_reg     <= cfg_data[CMD_W-1:0];
                default:         ;
            endcase
        end
    end

    // Sequencer: next state and result fields
    always_comb
    begin
        state_next     = state_reg;
        bit_cnt_next   = bit_cnt_reg;
        ctrl           = '0;
        valid_next     = 1'b0;
        bit_index_next = bit_cnt_reg;
        last_next      = 1'b0;
        status_next    = STATUS_OK;
        zero_next      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    valid_next     = 1'b1;
                    bit_index_next = '0;
                    if (range_err)
                    begin
                        // Drop the frame and report a single error result.
                        status_next = STATUS_RANGE;
                        last_next   = 1'b1;
                        zero_next   = 1'b1;
                    end
                    else
                    begin
                        ctrl.load    = 1'b1;
                        bit_cnt_next = BIDX_W'(1);
                        state_next   = ST_SEND;
                    end
                end
            end
            ST_SEND:
            begin
                valid_next   = 1'b1;
                ctrl.advance = 1'b1;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == LAST_BIT)
                begin
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Merge the lanes into the result register
    always_comb
    begin
        for (int i = 0; i < CH_MAX; i++)
        begin
            pulse_next[i] = zero_next ? '0 : lane_pulse[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_index_reg <= bit_index_next;
        last_reg      <= last_next;
        status_reg    <= status_next;
        for (int i = 0; i < CH_MAX; i++)
        begin
            pulse_reg[i] <= pulse_next[i];
        end
    end

    assign valid     = valid_reg;
    assign bit_index = bit_index_reg;
    assign last      = last_reg;
    assign status    = status_reg;
    assign pulse_ch0 = pulse_reg[0];
    assign pulse_ch1 = pulse_reg[1];
    assign pulse_ch2 = pulse_reg[2];
    assign pulse_ch3 = pulse_reg[3];
    assign pulse_ch4 = pulse_reg[4];
    assign pulse_ch5 = pulse_reg[5];

    `ASSERT_CLK(a_accept_gives_result, (start && !busy) |=> valid,
        "accepted transaction gave no result")
    `ASSERT_IMPLIES(a_busy_shows_result, busy, valid_reg,
        "sending but no result shown")
    `ASSERT_IMPLIES(a_error_single, valid_reg && (status_reg == STATUS_RANGE),
        last_reg && (bit_index_reg == '0),
        "range error result not a single first result")
    `ASSERT_CLK(a_bits_in_order,
        (valid_reg && !last_reg) |=> (valid_reg && (bit_index_reg == $past(bit_index_reg) + 1'b1)),
        "frame bits not consecutive")

endmodule
